// ----- rtl/pba_pkg.sv -----
// Shared constants, types and a helper function for the port bitmap allocator.
package pba_pkg;

    // Map geometry: one bit per port, packed into words.
    localparam int WORD_BITS = 32;
    localparam int PORT_BITS = 16;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int ADDR_W    = PORT_BITS - BIT_W;
    localparam int MAP_WORDS = (1 << PORT_BITS) / WORD_BITS;

    // Reset value of the first dynamic port.
    localparam logic [PORT_BITS-1:0] FDP_RESET = PORT_BITS'(49152);

    // Operation codes; the fourth code is undefined, leaves the map alone and returns a failed response.
    typedef logic [1:0] op_t;
    localparam op_t OP_ALLOC   = 2'd0;
    localparam op_t OP_RESERVE = 2'd1;
    localparam op_t OP_FREE    = 2'd2;

    typedef logic [PORT_BITS-1:0] port_t;
    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [ADDR_W-1:0]    waddr_t;
    typedef logic [BIT_W-1:0]     bidx_t;

    // Index of the lowest set bit of a word; zero when no bit is set.
    function automatic bidx_t find_first(input word_t v);
        bidx_t idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- rtl/pba_if.sv -----
// Channel interfaces of the port bitmap allocator: request, response and configuration.
interface pba_req_if
    import pba_pkg::*;
();
    logic  valid;
    logic  ready;
    op_t   operation;
    port_t port;

    modport source (output valid, output operation, output port, input ready);
    modport sink   (input valid, input operation, input port, output ready);
endinterface

interface pba_rsp_if
    import pba_pkg::*;
();
    logic  valid;
    logic  ready;
    port_t result_port;
    logic  success;

    modport source (output valid, output result_port, output success, input ready);
    modport sink   (input valid, input result_port, input success, output ready);
endinterface

interface pba_cfg_if
    import pba_pkg::*;
();
    logic  valid;
    logic  ready;
    port_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/pba_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module pba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/port_bitmap_allocator.sv -----
// Top level of the port bitmap allocator: sequencer, scan unit and map memory.
//
//  channel | dir | handshake     | word contents
//  --------+-----+---------------+------------------------------------
//  req     | in  | valid / ready | operation, port
//  rsp     | out | valid / ready | result_port, success
//  cfg     | in  | valid / ready | data (first dynamic port)
//
// Reserve and free pass through the read, check and done states between accepts, an
// undefined operation through done only. Dynamic allocation reads and checks one map
// word at a time, as the single read port and one-word mask and find-first unit allow.
// After reset the 2048 map words are cleared one word a cycle with req not ready.
// A finished word waits in the output register; a new request is taken meanwhile,
// and the sequencer holds its next result until the output register is free.
module port_bitmap_allocator
    import pba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pba_req_if.sink   req,
    pba_rsp_if.source rsp,
    pba_cfg_if.sink   cfg
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    port_t  port_reg, port_next;
    port_t  lo_reg, lo_next;
    port_t  hi_reg, hi_next;
    waddr_t w_reg, w_next;
    logic   phase_reg, phase_next;
    port_t  last_reg, last_next;
    port_t  fdp_reg, fdp_next;
    waddr_t clr_reg, clr_next;
    port_t  res_port_reg, res_port_next;
    logic   res_ok_reg, res_ok_next;
    logic   out_valid_reg, out_valid_next;
    port_t  out_port_reg, out_port_next;
    logic   out_ok_reg, out_ok_next;

    // Map memory signals.
    logic   ram_we;
    waddr_t ram_waddr;
    word_t  ram_wdata;
    logic   ram_re;
    word_t  ram_rdata;

    // Scan helpers.
    port_t  start_inc;
    port_t  start;
    word_t  mask;
    word_t  cand;
    bidx_t  hit;
    word_t  hit_bit;
    word_t  own_bit;
    logic   out_free;

    pba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (w_reg),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid       = out_valid_reg;
    assign rsp.result_port = out_port_reg;
    assign rsp.success     = out_ok_reg;
    assign out_free        = !out_valid_reg || rsp.ready;

    // Start of a dynamic scan: one past the last port, wrapping to the dynamic range.
    assign start_inc = last_reg + port_t'(1);
    assign start     = (start_inc == '0) ? fdp_reg : start_inc;

    // Mask of ports in the current word that lie inside [lo, hi] and are not port zero.
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            mask[i] = ((w_reg != lo_reg[PORT_BITS-1:BIT_W]) ||
                       (BIT_W'(i) >= lo_reg[BIT_W-1:0])) &&
                      ((w_reg != hi_reg[PORT_BITS-1:BIT_W]) ||
                       (BIT_W'(i) <= hi_reg[BIT_W-1:0])) &&
                      !((w_reg == '0) && (i == 0));
        end
    end

    assign cand    = ~ram_rdata & mask;
    assign hit     = find_first(cand);
    assign hit_bit = word_t'(1) << hit;
    assign own_bit = word_t'(1) << port_reg[BIT_W-1:0];

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        port_next     = port_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        w_next        = w_reg;
        phase_next    = phase_reg;
        last_next     = last_reg;
        fdp_next      = fdp_reg;
        clr_next      = clr_reg;
        res_port_next = res_port_reg;
        res_ok_next   = res_ok_reg;
        ram_we        = 1'b0;
        ram_waddr     = w_reg;
        ram_wdata     = ram_rdata;
        ram_re        = 1'b0;

        if (cfg.valid)
        begin
            fdp_next = cfg.data;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + waddr_t'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next   = req.operation;
                    port_next = req.port;
                    w_next    = req.port[PORT_BITS-1:BIT_W];
                    unique case (req.operation)
                        OP_ALLOC:
                        begin
                            last_next  = start;
                            lo_next    = start;
                            hi_next    = '1;
                            w_next     = start[PORT_BITS-1:BIT_W];
                            phase_next = 1'b0;
                            state_next = ST_READ;
                        end
                        OP_RESERVE, OP_FREE:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            res_port_next = '0;
                            res_ok_next   = 1'b0;
                            state_next    = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                res_port_next = '0;
                priority if (op_reg == OP_RESERVE)
                begin
                    res_ok_next = !ram_rdata[port_reg[BIT_W-1:0]];
                    ram_we      = !ram_rdata[port_reg[BIT_W-1:0]];
                    ram_wdata   = ram_rdata | own_bit;
                    state_next  = ST_DONE;
                end
                else if (op_reg == OP_FREE)
                begin
                    res_ok_next = 1'b1;
                    ram_we      = 1'b1;
                    ram_wdata   = ram_rdata & ~own_bit;
                    state_next  = ST_DONE;
                end
                else if (cand != '0)
                begin
                    // Free port found: mark it and hand it out.
                    ram_we        = 1'b1;
                    ram_wdata     = ram_rdata | hit_bit;
                    res_port_next = {w_reg, hit};
                    res_ok_next   = 1'b1;
                    last_next     = {w_reg, hit};
                    state_next    = ST_DONE;
                end
                else if (w_reg != hi_reg[PORT_BITS-1:BIT_W])
                begin
                    w_next     = w_reg + waddr_t'(1);
                    state_next = ST_READ;
                end
                else if (!phase_reg && (last_reg > fdp_reg))
                begin
                    // Wrap pass from the first dynamic port up to just before the start.
                    phase_next = 1'b1;
                    lo_next    = fdp_reg;
                    hi_next    = last_reg - port_t'(1);
                    w_next     = fdp_reg[PORT_BITS-1:BIT_W];
                    state_next = ST_READ;
                end
                else
                begin
                    res_ok_next = 1'b0;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_port_next  = out_port_reg;
        out_ok_next    = out_ok_reg;
        if (state_reg == ST_DONE && out_free)
        begin
            out_valid_next = 1'b1;
            out_port_next  = res_port_reg;
            out_ok_next    = res_ok_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state and architectural registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            op_reg        <= OP_ALLOC;
            phase_reg     <= 1'b0;
            last_reg      <= FDP_RESET - port_t'(1);
            fdp_reg       <= FDP_RESET;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            phase_reg     <= phase_next;
            last_reg      <= last_next;
            fdp_reg       <= fdp_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        port_reg     <= port_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        w_reg        <= w_next;
        res_port_reg <= res_port_next;
        res_ok_reg   <= res_ok_next;
        out_port_reg <= out_port_next;
        out_ok_reg   <= out_ok_next;
    end

endmodule

// ----- rtl/pba_checker.sv -----
// Port-level checker for the port bitmap allocator and its bind statement.
module pba_checker
    import pba_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  req_valid,
    input logic  req_ready,
    input logic  rsp_valid,
    input logic  rsp_ready,
    input port_t rsp_result_port,
    input logic  rsp_success
);

    // A response word that is not taken holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_port)
            && $stable(rsp_success))
        else $error("response word changed while stalled");

    // A nonzero handed-out port always comes with success.
    a_port_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_result_port != '0) |-> rsp_success)
        else $error("nonzero port reported without success");

    // Every request passes through at least one busy state, so ready drops after an accept.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request ready right after an accept");

    // The map clear after reset keeps requests out.
    a_clear: assert property (@(posedge clk)
        !rst_n |=> !req_ready)
        else $error("request ready during the map clear");

endmodule

bind port_bitmap_allocator pba_checker u_pba_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_result_port (rsp.result_port),
    .rsp_success     (rsp.success)
);

// ----- sim/port_bitmap_allocator_tb.sv -----
// Self-checking testbench for the port bitmap allocator with a built-in occupancy predictor.
`timescale 1ns / 100ps

module port_bitmap_allocator_tb;
    import pba_pkg::*;

    localparam int  TOP_PORT  = (1 << PORT_BITS) - 1;
    localparam op_t OP_UNDEF  = 2'd3;
    localparam int  SHOW_MAX  = 10;
    localparam int  SCAN_RUN  = 70;

    // Expected response word: handed-out port and success flag.
    typedef struct packed {
        port_t result_port;
        logic  success;
    } grant_t;

    logic clk = 1'b0;
    logic rst_n;

    pba_req_if req_ch();
    pba_rsp_if rsp_ch();
    pba_cfg_if cfg_ch();

    port_bitmap_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Predicted allocator state: occupancy bits, last dynamic port, range base.
    bit     port_taken [0:TOP_PORT];
    port_t  last_handed = FDP_RESET - 1'b1;
    port_t  dyn_base    = FDP_RESET;

    grant_t grant_q [$];
    int     mismatches  = 0;
    bit     quiet       = 1'b0;
    int     hold_cycles = 0;
    int     rsp_stall   = 0;

    always #5 clk = ~clk;

    // Run limit; far above the slowest legal run including the map clear.
    initial
    begin
        #(100_000_000);
        $display("Some tests failed");
        $finish;
    end

    // Apply one request to the predicted state and return the expected word.
    function automatic grant_t predict_grant(op_t op, port_t p);
        grant_t g;
        port_t  start;
        int     hit;
        g   = '0;
        hit = -1;
        case (op)
            OP_ALLOC:
            begin
                start = last_handed + 1'b1;
                if (start == '0)
                    start = dyn_base;
                last_handed = start;
                // Next-fit pass from the start to the top of the port space.
                for (int q = start; q <= TOP_PORT && hit < 0; q++)
                begin
                    if (q != 0 && !port_taken[q])
                        hit = q;
                end
                // Wrap pass from the range base up to just before the start.
                if (hit < 0 && start > dyn_base)
                begin
                    for (int q = dyn_base; q < start && hit < 0; q++)
                    begin
                        if (q != 0 && !port_taken[q])
                            hit = q;
                    end
                end
                if (hit >= 0)
                begin
                    port_taken[hit] = 1'b1;
                    last_handed     = port_t'(hit);
                    g.result_port   = port_t'(hit);
                    g.success       = 1'b1;
                end
            end
            OP_RESERVE:
            begin
                if (!port_taken[p])
                begin
                    port_taken[p] = 1'b1;
                    g.success     = 1'b1;
                end
            end
            OP_FREE:
            begin
                port_taken[p] = 1'b0;
                g.success     = 1'b1;
            end
            default:
            begin
            end
        endcase
        return g;
    endfunction

    // Offer one request word after a random gap (none when quiet) and record its expected response.
    task automatic send_request(op_t op, port_t p);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.port      <= p;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        grant_q.push_back(predict_grant(op, p));
    endtask

    // Drop the request and wait until every expected response has arrived.
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
    endtask

    // Write the first dynamic port while the block is idle.
    task automatic write_first_dynamic(port_t value);
        wait_drained();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        dyn_base = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Response side: per-word random stall plus an optional long hold-off.
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (rsp_stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each accepted response word with the oldest expectation.
    initial
    begin
        grant_t want;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                rsp_stall = quiet ? 0 : $urandom_range(0, 11);
                if (grant_q.size() == 0)
                begin
                    if (mismatches < SHOW_MAX)
                        $display("unexpected response: port %0d success %0b",
                                 rsp_ch.result_port, rsp_ch.success);
                    mismatches++;
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (rsp_ch.result_port !== want.result_port ||
                        rsp_ch.success !== want.success)
                    begin
                        if (mismatches < SHOW_MAX)
                            $display({"mismatch: expected port %0d success %0b, ",
                                      "got port %0d success %0b"},
                                     want.result_port, want.success,
                                     rsp_ch.result_port, rsp_ch.success);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Directed: every operation, port extremes, taken and already free ports.
    task automatic test_basic_ops();
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, port_t'(TOP_PORT));
        send_request(OP_RESERVE, '0);
        send_request(OP_RESERVE, port_t'(TOP_PORT));
        send_request(OP_RESERVE, port_t'(TOP_PORT));
        send_request(OP_FREE, port_t'(TOP_PORT));
        send_request(OP_FREE, port_t'(TOP_PORT));
        send_request(OP_RESERVE, port_t'(49154));
        send_request(OP_ALLOC, '0);
        send_request(OP_UNDEF, port_t'(12345));
        send_request(OP_FREE, '0);
        send_request(OP_RESERVE, port_t'(32768));
        send_request(OP_FREE, port_t'(32768));
        send_request(OP_ALLOC, port_t'(21845));
    endtask

    // The response side holds off for a long stretch while requests keep coming.
    task automatic test_output_stall();
        quiet       = 1'b1;
        hold_cycles = 300;
        for (int i = 0; i < 30; i++)
            send_request(op_t'(i % 3), port_t'($urandom_range(0, TOP_PORT)));
        quiet = 1'b0;
        wait_drained();
    endtask

    // Taken ports just above the scan start push the next-fit scan across map words,
    // then the range base is moved above the start and to the top port.
    task automatic test_scan_wrap();
        port_t base;
        base  = last_handed + 1'b1;
        quiet = 1'b1;
        for (int i = 0; i < SCAN_RUN; i++)
        begin
            if (!port_taken[port_t'(base + i)])
                send_request(OP_RESERVE, port_t'(base + i));
        end
        quiet = 1'b0;
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, port_t'(base + 5));
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        // Narrow range above the scan start: no wrap pass is made.
        write_first_dynamic(port_t'(65504));
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, port_t'(65520));
        send_request(OP_ALLOC, '0);
        // Single-port range at the top of the port space.
        write_first_dynamic(port_t'(TOP_PORT));
        send_request(OP_FREE, port_t'(TOP_PORT));
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
    endtask

    // Random mix biased toward the dynamic range and the scan position.
    task automatic test_random_mix(int count);
        op_t   op;
        port_t p;
        int    sel;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 59) == 0)
                wait_drained();
            sel = $urandom_range(0, 19);
            if (sel < 8)
                op = OP_ALLOC;
            else if (sel < 13)
                op = OP_RESERVE;
            else if (sel < 19)
                op = OP_FREE;
            else
                op = OP_UNDEF;
            sel = $urandom_range(0, 9);
            if (sel < 5)
                p = port_t'(dyn_base + $urandom_range(0, TOP_PORT - dyn_base));
            else if (sel < 7)
                p = port_t'(last_handed + $urandom_range(0, 64) - 32);
            else
                p = port_t'($urandom_range(0, TOP_PORT));
            send_request(op, p);
        end
        quiet = 1'b0;
    endtask

    // Range settings at the lowest and the highest base and the reset value, then a random one.
    task automatic test_config_sweep();
        write_first_dynamic(port_t'(1));
        test_random_mix(100);
        write_first_dynamic(port_t'(TOP_PORT));
        test_random_mix(40);
        write_first_dynamic(FDP_RESET);
        test_random_mix(120);
        write_first_dynamic(port_t'($urandom_range(1, TOP_PORT)));
        test_random_mix(100);
    endtask

    // Main sequence.
    initial
    begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_ALLOC;
        req_ch.port      = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_output_stall();
        test_scan_wrap();
        test_config_sweep();

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && grant_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
